@@ hdl/rtc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types, codes and the month-length table of the calendar counter.
// ----------------------------------------------------------------------------
package rtc_pkg;

  // Default width of the year counter.
  localparam int YEAR_BITS_DEF = 16;

  // Bit position of the year within a beat (the fields below it take 26 bits).
  localparam int YEAR_LSB = 26;

  // Largest value before each field rolls over; for the month, the value it wraps at.
  localparam logic [5:0] SEC_LAST   = 6'd59;
  localparam logic [5:0] MIN_LAST   = 6'd59;
  localparam logic [4:0] HOUR_LAST  = 5'd23;
  localparam logic [4:0] MONTH_WRAP = 5'd13;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_SET  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NOP  = 2'd3
  } rtc_func_t;

  // Time of day and date without the year; sec sits in the lowest bits.
  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] min;
    logic [5:0] sec;
  } rtc_hms_t;

  // Days in a month. February is always 28 days; invalid months count as 30.
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

@@ hdl/rtc_tick.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_tick
// Advances a time and date by one second through the cascaded fields.
// ----------------------------------------------------------------------------
module rtc_tick #(
  parameter int YEAR_BITS = rtc_pkg::YEAR_BITS_DEF
) (
  input  rtc_pkg::rtc_hms_t       t_in,
  input  logic [YEAR_BITS-1:0]    year_in,
  output rtc_pkg::rtc_hms_t       t_out,
  output logic [YEAR_BITS-1:0]    year_out
);
  import rtc_pkg::*;

  logic       sec_wrap;
  logic       min_wrap;
  logic       hour_wrap;
  logic [5:0] day_inc;
  logic       day_wrap;
  logic [4:0] mon_inc;
  logic       mon_wrap;

  always_comb begin
    sec_wrap  = (t_in.sec >= SEC_LAST);
    min_wrap  = (t_in.min >= MIN_LAST);
    hour_wrap = (t_in.hour >= HOUR_LAST);
    day_inc   = {1'b0, t_in.day} + 6'd1;
    day_wrap  = (day_inc > {1'b0, month_len(t_in.month)});
    mon_inc   = {1'b0, t_in.month} + 5'd1;
    mon_wrap  = (mon_inc >= MONTH_WRAP);

    t_out    = t_in;
    year_out = year_in;
    t_out.sec = sec_wrap ? 6'd0 : t_in.sec + 6'd1;
    if (sec_wrap) begin
      t_out.min = min_wrap ? 6'd0 : t_in.min + 6'd1;
      if (min_wrap) begin
        t_out.hour = hour_wrap ? 5'd0 : t_in.hour + 5'd1;
        if (hour_wrap) begin
          t_out.day = day_wrap ? 5'd1 : day_inc[4:0];
          if (day_wrap) begin
            t_out.month = mon_wrap ? 4'd1 : mon_inc[3:0];
            if (mon_wrap) begin
              year_out = year_in + {{(YEAR_BITS-1){1'b0}}, 1'b1};
            end
          end
        end
      end
    end
  end

endmodule

@@ hdl/rtc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_core
// Running time, pending set buffer and updated flag, with next-state logic.
// ----------------------------------------------------------------------------
module rtc_core #(
  parameter int YEAR_BITS = rtc_pkg::YEAR_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  rtc_pkg::rtc_func_t      func,
  input  rtc_pkg::rtc_hms_t       set_hms,
  input  logic [YEAR_BITS-1:0]    set_year,
  output rtc_pkg::rtc_hms_t       res_hms,
  output logic [YEAR_BITS-1:0]    res_year,
  output logic                    res_upd
);
  import rtc_pkg::*;

  rtc_hms_t             cur_hms_r, cur_hms_nxt;
  logic [YEAR_BITS-1:0] cur_year_r, cur_year_nxt;
  rtc_hms_t             pend_hms_r, pend_hms_nxt;
  logic [YEAR_BITS-1:0] pend_year_r, pend_year_nxt;
  logic                 pend_flag_r, pend_flag_nxt;
  logic                 upd_flag_r, upd_flag_nxt;

  rtc_hms_t             base_hms;
  logic [YEAR_BITS-1:0] base_year;
  rtc_hms_t             tick_hms;
  logic [YEAR_BITS-1:0] tick_year;

  // A pending set is applied just before the tick counts.
  assign base_hms  = pend_flag_r ? pend_hms_r  : cur_hms_r;
  assign base_year = pend_flag_r ? pend_year_r : cur_year_r;

  rtc_tick #(.YEAR_BITS(YEAR_BITS)) u_tick (
    .t_in    (base_hms),
    .year_in (base_year),
    .t_out   (tick_hms),
    .year_out(tick_year)
  );

  always_comb begin
    cur_hms_nxt   = cur_hms_r;
    cur_year_nxt  = cur_year_r;
    pend_hms_nxt  = pend_hms_r;
    pend_year_nxt = pend_year_r;
    pend_flag_nxt = pend_flag_r;
    upd_flag_nxt  = upd_flag_r;
    res_hms       = cur_hms_r;
    res_year      = cur_year_r;
    res_upd       = upd_flag_r;
    unique case (func)
      FUNC_TICK: begin
        cur_hms_nxt   = tick_hms;
        cur_year_nxt  = tick_year;
        pend_flag_nxt = 1'b0;
        upd_flag_nxt  = 1'b1;
        res_hms       = tick_hms;
        res_year      = tick_year;
        res_upd       = 1'b1;
      end
      FUNC_SET: begin
        pend_hms_nxt  = set_hms;
        pend_year_nxt = set_year;
        pend_flag_nxt = 1'b1;
      end
      FUNC_READ: begin
        upd_flag_nxt = 1'b0;
      end
      FUNC_NOP: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_hms_r   <= '0;
      cur_year_r  <= '0;
      pend_hms_r  <= '0;
      pend_year_r <= '0;
      pend_flag_r <= 1'b0;
      upd_flag_r  <= 1'b0;
    end else if (step_en) begin
      cur_hms_r   <= cur_hms_nxt;
      cur_year_r  <= cur_year_nxt;
      pend_hms_r  <= pend_hms_nxt;
      pend_year_r <= pend_year_nxt;
      pend_flag_r <= pend_flag_nxt;
      upd_flag_r  <= upd_flag_nxt;
    end
  end

endmodule

@@ hdl/rtc_calendar_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_calendar_counter
// Calendar clock counter with buffered time set and read-to-clear flag.
// ----------------------------------------------------------------------------
// Every input beat yields exactly one result beat. The block takes one beat per
// clock cycle unless out_tready holds it back, and each beat passes through the
// input register and then the result register. The per-beat work is the
// one-second cascade (seconds, minutes, hours, day against the month-length
// table, month, year), done combinationally between those two registers, so
// that, stalls aside, the rate is one beat per cycle for any mix of ticks, sets
// and reads. A set only fills a pending buffer; the next tick loads it and then
// counts. A read returns the updated flag and then clears it. The year wraps
// modulo 2^YEAR_BITS. There is no clearing pass after reset.
module rtc_calendar_counter #(
  parameter int YEAR_BITS = rtc_pkg::YEAR_BITS_DEF,
  localparam int IN_W  = ((rtc_pkg::YEAR_LSB + YEAR_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((rtc_pkg::YEAR_LSB + YEAR_BITS + 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // set_sec, set_min, set_hour, set_day, set_month, set_year, zero fill
  input  logic [IN_W-1:0]  in_tdata,
  // func
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // sec, minute, hour, day, month, year, updated, zero fill
  output logic [OUT_W-1:0] out_tdata
);
  import rtc_pkg::*;

  localparam int UPD_BIT = YEAR_LSB + YEAR_BITS;

  // Input register stage.
  logic                 s1_valid_r;
  rtc_func_t            s1_func_r;
  rtc_hms_t             s1_hms_r;
  logic [YEAR_BITS-1:0] s1_year_r;

  // Result register stage.
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_data_r;

  logic                 out_load;
  logic                 step_en;
  logic                 in_fire;

  rtc_hms_t             res_hms;
  logic [YEAR_BITS-1:0] res_year;
  logic                 res_upd;
  logic [OUT_W-1:0]     res_data;

  // The result register can take a new beat when empty or being drained.
  assign out_load  = !out_valid_r || out_tready;
  assign step_en   = s1_valid_r && out_load;
  assign in_tready = !s1_valid_r || out_load;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= rtc_func_t'(in_tuser);
      s1_hms_r  <= rtc_hms_t'(in_tdata[YEAR_LSB-1:0]);
      s1_year_r <= in_tdata[YEAR_LSB +: YEAR_BITS];
    end
  end

  // State is committed only when the beat moves on to the result register.
  rtc_core #(.YEAR_BITS(YEAR_BITS)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .func    (s1_func_r),
    .set_hms (s1_hms_r),
    .set_year(s1_year_r),
    .res_hms (res_hms),
    .res_year(res_year),
    .res_upd (res_upd)
  );

  always_comb begin
    res_data                           = '0;
    res_data[YEAR_LSB-1:0]             = res_hms;
    res_data[YEAR_LSB +: YEAR_BITS]    = res_year;
    res_data[UPD_BIT]                  = res_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A tick always reports the updated flag as set.
  a_tick_sets_updated: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && s1_func_r == FUNC_TICK) |=> out_data_r[UPD_BIT])
    else $error("tick result without updated flag");

  // Seconds after a tick are always in range, whatever was loaded.
  a_tick_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && s1_func_r == FUNC_TICK) |=> (out_data_r[5:0] <= SEC_LAST))
    else $error("tick result seconds out of range");

  // With the result register empty the input side never stalls.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while result register empty");

  // A result beat appears only for a beat held in the input register.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !s1_valid_r) |=> !out_valid_r)
    else $error("result beat without an input beat");

endmodule

@@ sim/rtc_calendar_counter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_calendar_counter_tb
// Self-checking bench for the calendar counter: a directed table, then random
// beats, compared field by field against typed rows or a cycle-free calendar predictor.
// ----------------------------------------------------------------------------
// The table walks the corners first: the state straight out of reset, the full
// cascade from the last second of a year into the next one, out-of-range set
// values, invalid months, a set that is overwritten before the tick that loads
// it, a read that returns the flag before clearing it, and the unused function
// code. The random part mixes ticks, sets, reads and the unused code, with most
// sets placed just before a rollover so that the cascades fire often. Both
// handshakes idle at random; there is one long receiver hold-off that backs the
// block up, one pause until the block drains, and one stretch without idling.
module rtc_calendar_counter_tb;
  import rtc_pkg::*;

  localparam int YEAR_BITS = YEAR_BITS_DEF;
  localparam int IN_W      = ((YEAR_LSB + YEAR_BITS + 7) / 8) * 8;
  localparam int OUT_W     = ((YEAR_LSB + YEAR_BITS + 1 + 7) / 8) * 8;
  localparam int SET_BITS  = YEAR_LSB + YEAR_BITS;
  localparam int RES_BITS  = YEAR_LSB + YEAR_BITS + 1;
  localparam int unsigned YEAR_MASK = 32'((64'd1 << YEAR_BITS) - 64'd1);

  localparam int N_DIR        = 25;
  localparam int N_RAND       = 700;
  localparam int HOLD_AT      = 150;   // random beat at which the receiver stalls
  localparam int HOLD_CYCLES  = 300;
  localparam int PAUSE_AT     = 300;   // random beat before which the sender drains
  localparam int CALM_FROM    = 450;   // no idling on either side in this window
  localparam int CALM_TO      = 600;
  localparam int DRAIN_CYCLES = 20;    // leave ample margin
  localparam int CYCLE_LIMIT  = 100000;

  // Days per month code; code 0 and codes 13 to 15 count as 30 days.
  localparam int DAYS_IN [16] = '{30, 31, 28, 31, 30, 31, 30, 31,
                                  31, 30, 31, 30, 31, 30, 30, 30};

  // One result beat, laid out exactly as out_tdata below the zero fill.
  typedef struct packed {
    logic                 updated;
    logic [YEAR_BITS-1:0] year;
    logic [3:0]           month;
    logic [4:0]           day;
    logic [4:0]           hour;
    logic [5:0]           minute;
    logic [5:0]           sec;
  } cal_result_t;

  // A directed row: function, set fields (sec, min, hour, day, month, year),
  // and, where it is obvious, the result typed in (same order, then updated).
  typedef struct {
    rtc_func_t func;
    int        f [6];
    bit        typed;
    int        w [7];
  } dir_row_t;

  dir_row_t plan [N_DIR] = '{
    '{FUNC_READ, '{0, 0, 0, 0, 0, 0},            1, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_TICK, '{0, 0, 0, 0, 0, 0},            1, '{1, 0, 0, 0, 0, 0, 1}},
    '{FUNC_NOP,  '{0, 0, 0, 0, 0, 0},            1, '{1, 0, 0, 0, 0, 0, 1}},
    '{FUNC_READ, '{0, 0, 0, 0, 0, 0},            1, '{1, 0, 0, 0, 0, 0, 1}},
    '{FUNC_READ, '{0, 0, 0, 0, 0, 0},            1, '{1, 0, 0, 0, 0, 0, 0}},
    '{FUNC_SET,  '{59, 59, 23, 31, 12, 65535},   1, '{1, 0, 0, 0, 0, 0, 0}},
    '{FUNC_TICK, '{0, 0, 0, 0, 0, 0},            1, '{0, 0, 0, 1, 1, 0, 1}},
    '{FUNC_SET,  '{59, 59, 23, 28, 2, 1999},     0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_TICK, '{0, 0, 0, 0, 0, 0},            0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_SET,  '{63, 63, 31, 31, 15, 65535},   0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_TICK, '{0, 0, 0, 0, 0, 0},            0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_SET,  '{0, 0, 0, 0, 0, 0},            0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_TICK, '{0, 0, 0, 0, 0, 0},            0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_SET,  '{59, 59, 23, 30, 4, 7},        0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_TICK, '{0, 0, 0, 0, 0, 0},            0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_SET,  '{59, 59, 23, 30, 0, 42},       0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_TICK, '{0, 0, 0, 0, 0, 0},            0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_SET,  '{58, 59, 23, 31, 13, 100},     0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_READ, '{0, 0, 0, 0, 0, 0},            0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_TICK, '{0, 0, 0, 0, 0, 0},            0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_TICK, '{0, 0, 0, 0, 0, 0},            0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_SET,  '{0, 0, 0, 1, 1, 0},            0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_SET,  '{45, 30, 12, 15, 6, 2024},     0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_TICK, '{0, 0, 0, 0, 0, 0},            0, '{0, 0, 0, 0, 0, 0, 0}},
    '{FUNC_READ, '{0, 0, 0, 0, 0, 0},            0, '{0, 0, 0, 0, 0, 0, 0}}
  };

  // Every DUT input holds a known value from time zero.
  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic [1:0]       in_tuser   = FUNC_TICK;
  logic             out_tready = 1'b0;
  logic             in_tready;
  logic             out_tvalid;
  logic [OUT_W-1:0] out_tdata;

  // Receiver control; hold_req and calm are written by the sender with nonblocking assignments.
  logic hold_req = 1'b0;
  logic calm     = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  cal_result_t pending_results [$];
  int errors       = 0;
  int beats_in     = 0;
  int results_seen = 0;
  int cycles       = 0;

  // Predictor state: the running time, the staged time of the last set and the
  // flag that says a tick has happened since the last read.
  int unsigned now_sec, now_min, now_hour, now_day, now_month, now_year;
  logic [SET_BITS-1:0] staged_time;
  bit staged, fresh;
  int sets_seen, day_rolls, year_wraps;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rtc_calendar_counter #(.YEAR_BITS(YEAR_BITS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic logic [IN_W-1:0] pack_set(input int sec, input int mn, input int hr,
                                               input int dy, input int mo, input int yr);
    logic [IN_W-1:0] d;
    d = '0;
    d[SET_BITS-1:0] = {yr[YEAR_BITS-1:0], mo[3:0], dy[4:0], hr[4:0], mn[5:0], sec[5:0]};
    return d;
  endfunction

  // Advances the calendar predictor by one accepted beat and returns the
  // result the block must produce for it.
  function automatic cal_result_t step_calendar(input rtc_func_t f,
                                                input logic [IN_W-1:0] d);
    cal_result_t r;
    if (f == FUNC_SET) begin
      staged_time = d[SET_BITS-1:0];
      staged      = 1'b1;
      sets_seen++;
    end else if (f == FUNC_TICK) begin
      // A staged time is loaded first; the tick then counts from it.
      if (staged) begin
        staged    = 1'b0;
        now_sec   = 32'(staged_time[5:0]);
        now_min   = 32'(staged_time[11:6]);
        now_hour  = 32'(staged_time[16:12]);
        now_day   = 32'(staged_time[21:17]);
        now_month = 32'(staged_time[25:22]);
        now_year  = 32'(staged_time[SET_BITS-1:YEAR_LSB]);
      end
      fresh = 1'b1;
      // Fields at or past their end roll over (time to 0, date to 1) and carry.
      if (now_sec < SEC_LAST) now_sec++;
      else begin
        now_sec = 0;
        if (now_min < MIN_LAST) now_min++;
        else begin
          now_min = 0;
          if (now_hour < HOUR_LAST) now_hour++;
          else begin
            now_hour = 0;
            now_day++;
            if (now_day > DAYS_IN[now_month[3:0]]) begin
              now_day = 1;
              now_month++;
              day_rolls++;
              if (now_month >= MONTH_WRAP) begin
                now_month = 1;
                now_year  = (now_year + 1) & YEAR_MASK;
                year_wraps++;
              end
            end
          end
        end
      end
    end
    r.sec     = now_sec[5:0];
    r.minute  = now_min[5:0];
    r.hour    = now_hour[4:0];
    r.day     = now_day[4:0];
    r.month   = now_month[3:0];
    r.year    = now_year[YEAR_BITS-1:0];
    r.updated = fresh;
    // A read reports the flag first and clears it afterwards.
    if (f == FUNC_READ) fresh = 1'b0;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) note_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Offers one beat, optionally after random idle cycles, and records the
  // expectation at the edge where the block accepts it.
  task automatic push_beat(input rtc_func_t f, input logic [IN_W-1:0] d, input bit gaps,
                           input bit typed, input cal_result_t want);
    cal_result_t pred;
    while (gaps && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // The predictor always runs so its state follows the block; typed rows
    // take their expectation from the table instead.
    pred = step_calendar(f, d);
    pending_results.push_back(typed ? want : pred);
    beats_in++;
  endtask

  // Receiver: random stalls, one long hold-off on request, none while calm.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 27);
    end
  end

  // Result checker: every accepted result beat is matched to the oldest
  // expectation, one field at a time.
  cal_result_t got_res, want_res;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = out_tdata[RES_BITS-1:0];
      if (pending_results.size() == 0) begin
        note_mismatch("result beat with nothing expected");
      end else begin
        want_res = pending_results.pop_front();
        check_field("sec",     int'(got_res.sec),     int'(want_res.sec));
        check_field("minute",  int'(got_res.minute),  int'(want_res.minute));
        check_field("hour",    int'(got_res.hour),    int'(want_res.hour));
        check_field("day",     int'(got_res.day),     int'(want_res.day));
        check_field("month",   int'(got_res.month),   int'(want_res.month));
        check_field("year",    int'(got_res.year),    int'(want_res.year));
        check_field("updated", int'(got_res.updated), int'(want_res.updated));
      end
      results_seen++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding",
               cycles, pending_results.size());
      $display("rtc_calendar_counter verification failed");
      $finish;
    end
  end

  initial begin
    rtc_func_t       f;
    logic [IN_W-1:0] d;
    cal_result_t     want;
    int              roll, mo, sec, mn, hr, dy, yr;
    bit              quiet;

    now_sec = 0; now_min = 0; now_hour = 0;
    now_day = 0; now_month = 0; now_year = 0;
    staged_time = '0; staged = 1'b0; fresh = 1'b0;
    sets_seen = 0; day_rolls = 0; year_wraps = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (int i = 0; i < N_DIR; i++) begin
      want.sec     = 6'(plan[i].w[0]);
      want.minute  = 6'(plan[i].w[1]);
      want.hour    = 5'(plan[i].w[2]);
      want.day     = 5'(plan[i].w[3]);
      want.month   = 4'(plan[i].w[4]);
      want.year    = YEAR_BITS'(plan[i].w[5]);
      want.updated = 1'(plan[i].w[6]);
      push_beat(plan[i].func,
                pack_set(plan[i].f[0], plan[i].f[1], plan[i].f[2],
                         plan[i].f[3], plan[i].f[4], plan[i].f[5]),
                1'b1, plan[i].typed, want);
    end

    // Random part. Most sets land just short of a rollover so that the ticks
    // after them run through the minute, hour, day, month and year carries.
    for (int n = 0; n < N_RAND; n++) begin
      if (n == PAUSE_AT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (n == HOLD_AT) hold_req <= 1'b1;
      quiet = (n >= CALM_FROM) && (n < CALM_TO);
      calm <= quiet;

      roll = $urandom_range(99);
      if (roll < 55)      f = FUNC_TICK;
      else if (roll < 72) f = FUNC_SET;
      else if (roll < 93) f = FUNC_READ;
      else                f = FUNC_NOP;

      if (f == FUNC_SET && $urandom_range(99) < 70) begin
        mo  = ($urandom_range(99) < 40) ? 12 : $urandom_range(15, 0);
        sec = $urandom_range(63, 54);
        mn  = $urandom_range(63, 56);
        hr  = $urandom_range(31, 21);
        dy  = $urandom_range(31, DAYS_IN[mo] - 1);
        yr  = ($urandom_range(99) < 30) ? YEAR_MASK : $urandom_range(YEAR_MASK, 0);
      end else begin
        // Fully random field bits; on beats other than sets they are ignored.
        sec = $urandom_range(63, 0);
        mn  = $urandom_range(63, 0);
        hr  = $urandom_range(31, 0);
        dy  = $urandom_range(31, 0);
        mo  = $urandom_range(15, 0);
        yr  = $urandom_range(YEAR_MASK, 0);
      end
      d = pack_set(sec, mn, hr, dy, mo, yr);
      push_beat(f, d, !quiet, 1'b0, want);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d beats (%0d from the table), %0d results checked,",
             beats_in, N_DIR, results_seen);
    $display("with %0d sets, %0d month rollovers and %0d year rollovers predicted.",
             sets_seen, day_rolls, year_wraps);
    if (errors == 0) begin
      $display("rtc_calendar_counter verification clean");
    end else begin
      $display("rtc_calendar_counter verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rtc_pkg.sv
hdl/rtc_tick.sv
hdl/rtc_core.sv
hdl/rtc_calendar_counter.sv
sim/rtc_calendar_counter_tb.sv
